// File: design/dq_pkg.sv
package dq_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    wr_front;
    logic    wr_rear;
    logic    pop_front;
    logic    pop_rear;
    logic    list_rd;
    logic    res_valid;
    logic    res_from_mem;
    logic    res_last;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       list_last;
  } stat_t;

  // (base + off) mod DEPTH, base < DEPTH and off <= DEPTH
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: design/dq_ctrl.sv
module dq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  dq_pkg::stat_t stat_i,
  output dq_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POP  = 4'b0100,
    S_LIST = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = dq_pkg::ST_OK;
    busy_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (stat_i.op) inside
          dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
            cmd_o.res_valid = 1'b1;
            cmd_o.res_last  = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = dq_pkg::ST_FULL;
            end else begin
              cmd_o.wr_front = (stat_i.op == dq_pkg::OP_PUSH_FRONT);
              cmd_o.wr_rear  = (stat_i.op == dq_pkg::OP_PUSH_REAR);
            end
          end
          dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
            if (stat_i.empty) begin
              cmd_o.res_valid  = 1'b1;
              cmd_o.res_last   = 1'b1;
              cmd_o.res_status = dq_pkg::ST_EMPTY;
            end else begin
              cmd_o.pop_front = (stat_i.op == dq_pkg::OP_POP_FRONT);
              cmd_o.pop_rear  = (stat_i.op == dq_pkg::OP_POP_REAR);
              state_d         = S_POP;
            end
          end
          dq_pkg::OP_LIST: begin
            if (stat_i.empty) begin
              cmd_o.res_valid  = 1'b1;
              cmd_o.res_last   = 1'b1;
              cmd_o.res_status = dq_pkg::ST_EMPTY;
            end else begin
              cmd_o.list_rd = 1'b1;
              state_d       = S_LIST;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        cmd_o.res_valid    = 1'b1;
        cmd_o.res_from_mem = 1'b1;
        cmd_o.res_last     = 1'b1;
        state_d            = S_IDLE;
      end
      S_LIST: begin
        cmd_o.res_valid    = 1'b1;
        cmd_o.res_from_mem = 1'b1;
        cmd_o.res_last     = stat_i.list_last;
        if (stat_i.list_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.list_rd = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/dq_datapath.sv
module dq_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [2:0]                       opcode_i,
  input  logic signed [dq_pkg::VAL_W-1:0]  order_value_i,
  input  dq_pkg::cmd_t                     cmd_i,
  output dq_pkg::stat_t                    stat_o,
  output logic                             result_valid_o,
  output logic [1:0]                       status_o,
  output logic signed [dq_pkg::VAL_W-1:0]  out_value_o,
  output logic                             last_o
);

  logic [dq_pkg::VAL_W-1:0] mem [dq_pkg::DEPTH];
  logic [dq_pkg::VAL_W-1:0] rdata_q;
  logic [dq_pkg::VAL_W-1:0] val_q;
  logic [2:0]               op_q;
  logic [dq_pkg::IDX_W-1:0] head_q, head_d;
  logic [dq_pkg::CNT_W-1:0] count_q, count_d;
  logic [dq_pkg::CNT_W-1:0] idx_q, idx_d;
  logic [dq_pkg::IDX_W-1:0] front_slot, wr_addr, rd_addr;
  logic                     wr_en, rd_en;

  assign front_slot = dq_pkg::wrap_idx(head_q, dq_pkg::CNT_W'(dq_pkg::DEPTH - 1));
  assign wr_en      = cmd_i.wr_front | cmd_i.wr_rear;
  assign wr_addr    = cmd_i.wr_front ? front_slot : dq_pkg::wrap_idx(head_q, count_q);
  assign rd_en      = cmd_i.pop_front | cmd_i.pop_rear | cmd_i.list_rd;

  always_comb begin
    if (cmd_i.pop_front) begin
      rd_addr = head_q;
    end else if (cmd_i.pop_rear) begin
      rd_addr = dq_pkg::wrap_idx(head_q, count_q - dq_pkg::CNT_W'(1));
    end else begin
      rd_addr = dq_pkg::wrap_idx(head_q, idx_q);
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end
    if (cmd_i.list_rd) begin
      idx_d = idx_q + dq_pkg::CNT_W'(1);
    end
    if (cmd_i.wr_front) begin
      head_d = front_slot;
    end
    if (cmd_i.pop_front) begin
      head_d = dq_pkg::wrap_idx(head_q, dq_pkg::CNT_W'(1));
    end
    if (wr_en) begin
      count_d = count_q + dq_pkg::CNT_W'(1);
    end
    if (cmd_i.pop_front | cmd_i.pop_rear) begin
      count_d = count_q - dq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= order_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign stat_o.list_last = (idx_q == count_q);

  assign result_valid_o = cmd_i.res_valid;
  assign status_o       = cmd_i.res_status;
  assign last_o         = cmd_i.res_last;
  assign out_value_o    = cmd_i.res_from_mem ? rdata_q : '0;

endmodule

// File: design/double_ended_queue.sv
// Double-ended queue of 32-bit identifiers in a ring buffer of dq_pkg::DEPTH
// entries.
// Input: an item (opcode_i, order_value_i) is taken at a rising edge with
// start_i high and busy_o low. Opcodes: push front, push rear, pop front,
// pop rear, list all; other codes are dropped with no result.
// Output: each result shows on status_o, out_value_o and last_o for one
// cycle with result_valid_o high; last_o marks the final result of an item.
// The receiver cannot stall; results are never held back.
// Results, counted from the accepting edge:
//   push, or any empty/full answer: result in the next cycle.
//   pop: the entry memory has a registered read port, so the result comes
//   from the read register in the cycle after the read is issued.
//   list: the first read is issued, then one result per stored entry
//   follows until the last, and the block then returns to idle.
// One item is in flight at a time; busy_o stays high until its last result.
// Reset empties the queue (head and count cleared) and returns to idle; the
// entry memory itself is not cleared.
module double_ended_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [2:0]                      opcode_i,
  input  logic signed [dq_pkg::VAL_W-1:0] order_value_i,
  output logic                            result_valid_o,
  output logic [1:0]                      status_o,
  output logic signed [dq_pkg::VAL_W-1:0] out_value_o,
  output logic                            last_o
);

  dq_pkg::cmd_t  cmd;
  dq_pkg::stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  dq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .order_value_i (order_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .last_o        (last_o)
  );

endmodule

// File: design/dq_checker.sv
module dq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            result_valid_o,
  input logic [1:0]                      status_o,
  input logic signed [dq_pkg::VAL_W-1:0] out_value_o,
  input logic                            last_o
);

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result outside an item");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !busy_o && !result_valid_o)
    else $error("block still busy after last result");

  a_list_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("list stream broken");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != dq_pkg::ST_OK |-> last_o && out_value_o == '0)
    else $error("empty or full answer malformed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .status_o      (status_o),
  .out_value_o   (out_value_o),
  .last_o        (last_o)
);
